/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Address width of the text store and width of the sweep counter
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  // Payload field widths
  localparam int ACT_W  = 2;
  localparam int CHR_W  = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Actions
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Character codes
  localparam logic [CHR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHR_W-1:0] CH_TOP   = 8'h7F;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  // Work kinds decided by the front end
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
  localparam logic [KIND_W-1:0] K_BS    = 3'd1;
  localparam logic [KIND_W-1:0] K_TAB   = 3'd2;
  localparam logic [KIND_W-1:0] K_NL    = 3'd3;
  localparam logic [KIND_W-1:0] K_PRINT = 3'd4;
  localparam logic [KIND_W-1:0] K_CLEAR = 3'd5;
  localparam logic [KIND_W-1:0] K_READ  = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CHR_W-1:0] char_code;
    logic [IDX_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;
  } tcw_out_t;

  // Queue entry between front and back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHR_W-1:0]  char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_entry_t;

  // Front to back: head of the queue
  typedef struct packed {
    logic       valid;
    tcw_entry_t entry;
  } tcw_head_t;

  // Back to front: pop and intake enable
  typedef struct packed {
    logic pop;
    logic intake_en;
  } tcw_back_ctl_t;

endpackage : tcw_pkg
`default_nettype wire

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tcw_ram
`default_nettype wire

/* rtl/tcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front
// Input intake: classify each beat and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module tcw_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire tcw_pkg::tcw_in_t       in_data,
  output      tcw_pkg::tcw_head_t     head,
  input  wire tcw_pkg::tcw_back_ctl_t back_ctl
);
  import tcw_pkg::*;

  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  tcw_entry_t  entries [2];
  tcw_entry_t  classified;
  logic        push;

  // Decide what the back end has to do with this beat
  always_comb begin
    classified.char_code  = in_data.char_code;
    classified.cell_index = in_data.cell_index;
    case (in_data.action)
      ACT_PUT: begin
        if (in_data.char_code == CH_BS) begin
          classified.kind = K_BS;
        end else if (in_data.char_code == CH_TAB) begin
          classified.kind = K_TAB;
        end else if (in_data.char_code == CH_NL) begin
          classified.kind = K_NL;
        end else if (in_data.char_code >= CH_SPACE && in_data.char_code <= CH_TOP) begin
          classified.kind = K_PRINT;
        end else begin
          classified.kind = K_NOP;
        end
      end
      ACT_CLEAR: classified.kind = K_CLEAR;
      ACT_READ:  classified.kind = K_READ;
      default:   classified.kind = K_NOP;
    endcase
  end

  assign in_ready   = (count != 2'd2) && back_ctl.intake_en;
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (back_ctl.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, back_ctl.pop};
    end
  end

endmodule : tcw_front
`default_nettype wire

/* rtl/tcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back
// Execution: cursor update, text store writes, reads, scroll and clear sweeps.
// ----------------------------------------------------------------------------
module tcw_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
  input  wire tcw_pkg::tcw_head_t            head,
  output      tcw_pkg::tcw_back_ctl_t        back_ctl,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      tcw_pkg::tcw_out_t             out_data
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;

  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]  CNT_MOVE  = CNT_W'(CELLS - COLUMNS);
  localparam logic [COL_W:0]    COL_LIM   = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0]    ROW_LIM   = (ROW_W+1)'(ROWS);

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [COL_W-1:0]  col_pos, col_next;
  logic [ROW_W-1:0]  row_pos, row_next;
  logic [ATTR_W-1:0] attribute;
  logic              out_valid_next;
  logic [CELL_W-1:0] cell_data, cell_next;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [CELL_W-1:0] blank;
  logic [ADDR_W-1:0] put_addr;
  logic [COL_W:0]    colx, col_step;
  logic              row_inc;
  logic [ROW_W:0]    rowx;
  logic              wrap, scroll;
  logic [CNT_W-1:0]  wcnt;
  logic              in_range;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign blank    = {attribute, CH_SPACE};
  assign put_addr = ADDR_W'(32'(row_pos) * 32'(COLUMNS) + 32'(col_pos));
  assign wcnt     = cnt - CNT_W'(1);
  assign in_range = 32'(head.entry.cell_index) < 32'(CELLS);

  // Cursor step for the character at the head of the queue
  always_comb begin
    colx    = {1'b0, col_pos};
    row_inc = 1'b0;
    case (head.entry.kind)
      K_BS:    col_step = (col_pos != '0) ? colx - (COL_W+1)'(1) : colx;
      K_TAB:   col_step = (colx + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
      K_NL: begin
        col_step = '0;
        row_inc  = 1'b1;
      end
      K_PRINT: col_step = colx + (COL_W+1)'(1);
      default: col_step = colx;
    endcase
    wrap = (col_step >= COL_LIM);
    if (wrap) begin
      row_inc = 1'b1;
    end
    rowx   = {1'b0, row_pos} + {{ROW_W{1'b0}}, row_inc};
    scroll = (rowx >= ROW_LIM);
  end

  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    col_next           = col_pos;
    row_next           = row_pos;
    cell_next          = cell_data;
    out_valid_next     = out_valid && !out_ready;
    back_ctl.pop       = 1'b0;
    back_ctl.intake_en = (state != S_INIT);
    ram_we             = 1'b0;
    ram_waddr          = cnt[ADDR_W-1:0];
    ram_wdata          = blank;
    ram_re             = 1'b0;
    ram_raddr          = head.entry.cell_index[ADDR_W-1:0];

    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
        if (cnt == CNT_LAST) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (head.valid && !out_valid) begin
          back_ctl.pop = 1'b1;
          case (head.entry.kind)
            K_CLEAR: begin
              state_next = S_CLEAR;
              cnt_next   = '0;
            end
            K_READ: begin
              if (in_range) begin
                ram_re     = 1'b1;
                state_next = S_READ;
              end else begin
                cell_next      = '0;
                out_valid_next = 1'b1;
              end
            end
            default: begin
              if (head.entry.kind == K_PRINT) begin
                ram_we    = 1'b1;
                ram_waddr = put_addr;
                ram_wdata = {attribute, head.entry.char_code};
              end
              col_next  = wrap ? '0 : col_step[COL_W-1:0];
              cell_next = '0;
              if (scroll) begin
                row_next   = ROW_W'(ROWS - 1);
                state_next = S_SCROLL;
                cnt_next   = '0;
              end else begin
                row_next       = rowx[ROW_W-1:0];
                out_valid_next = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cell_next      = ram_rdata;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_SCROLL: begin
        // Read one row ahead, write the cell in the following cycle from the read data
        ram_re    = (cnt < CNT_MOVE);
        ram_raddr = ADDR_W'({1'b0, cnt} + (CNT_W+1)'(COLUMNS));
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = wcnt[ADDR_W-1:0];
          ram_wdata = (wcnt < CNT_MOVE) ? ram_rdata : blank;
        end
        if (cnt == CNT_END) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == CNT_LAST) begin
          col_next       = '0;
          row_next       = '0;
          cell_next      = '0;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_data.cursor_col    = col_pos;
  assign out_data.cursor_row    = row_pos;
  assign out_data.cursor_offset = OFF_W'(32'(row_pos) * 32'(COLUMNS) + 32'(col_pos));
  assign out_data.cell_data     = cell_data;

  always_ff @(posedge clk) begin
    cell_data <= cell_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      col_pos   <= '0;
      row_pos   <= '0;
      attribute <= ATTR_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      col_pos   <= col_next;
      row_pos   <= row_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        attribute <= cfg_wdata;
      end
    end
  end

endmodule : tcw_back
`default_nettype wire

/* rtl/text_console_char_writer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer
// 80x25 text console: put character, clear screen and read cell on one
// store of 16-bit cells, returning the cursor with every item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_ready  | in_data   (tcw_in_t)
//   out     | output    | out_valid / out_ready| out_data  (tcw_out_t)
//   cfg     | input     | cfg_we (no wait)     | cfg_wdata (attribute byte)
//
// A beat enters the queue, and the back end takes it from the queue head once it
// is idle and no result waits. Put, cursor moves and ignored codes finish when
// taken, a read after the registered store read in S_READ. Scroll sweeps the
// store, reading one row ahead of each write; clear writes every cell.
// Reset: a clearing pass over all CELLS (2000) cells blanks the store; in_ready
// stays low during it. The two-entry queue keeps taking beats while a result
// waits on out_ready.
// ----------------------------------------------------------------------------
module text_console_char_writer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire tcw_pkg::tcw_in_t           in_data,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      tcw_pkg::tcw_out_t          out_data,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  tcw_head_t     head;
  tcw_back_ctl_t back_ctl;

  // Front: classify beats and hold them until the back end is free
  tcw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .head    (head),
    .back_ctl(back_ctl)
  );

  // Back: carry out each item against the cursor and the text store
  tcw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .head     (head),
    .back_ctl (back_ctl),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule : text_console_char_writer
`default_nettype wire

/* verif/text_console_char_writer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the item, result and attribute ports of the console writer, keeps
// its own copy of the screen and cursor, and compares every result beat.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tcw_in_t             in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tcw_out_t            out_data,
  input  logic                cfg_we,
  input  logic [ATTR_W-1:0]   cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_checked,
  output int                  scroll_count
);

  logic [CELL_W-1:0] screen [0:CELLS-1];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr;
  tcw_out_t          predicted_results [$];

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
    cur_row = ROWS - 1;
    scroll_count++;
  endfunction

  function automatic void put_char(logic [CHR_W-1:0] code);
    int unsigned at;
    if (code == CH_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (code == CH_TAB) begin
      cur_col = (cur_col + 8) & ~32'd7;
    end else if (code == CH_NL) begin
      cur_col = 0;
      cur_row++;
    end else if (code >= CH_SPACE && code <= CH_TOP) begin
      at = cur_row * COLUMNS + cur_col;
      if (at < CELLS) screen[at] = {attr, code};
      cur_col++;
    end
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_up();
  endfunction

  // Apply one item to the screen copy and return the result it should give.
  function automatic tcw_out_t advance_console(tcw_in_t beat);
    tcw_out_t res;
    res = '0;
    case (beat.action)
      ACT_PUT:   put_char(beat.char_code);
      ACT_CLEAR: blank_screen();
      ACT_READ: begin
        if (beat.cell_index < CELLS) res.cell_data = screen[beat.cell_index];
      end
      default: ;
    endcase
    res.cursor_col    = cur_col[COL_W-1:0];
    res.cursor_row    = cur_row[ROW_W-1:0];
    res.cursor_offset = OFF_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_result(tcw_out_t want, tcw_out_t got);
    if (got.cursor_col !== want.cursor_col)
      log_failure($sformatf("cursor_col expected %0d got %0d",
                            want.cursor_col, got.cursor_col));
    if (got.cursor_row !== want.cursor_row)
      log_failure($sformatf("cursor_row expected %0d got %0d",
                            want.cursor_row, got.cursor_row));
    if (got.cursor_offset !== want.cursor_offset)
      log_failure($sformatf("cursor_offset expected %0d got %0d",
                            want.cursor_offset, got.cursor_offset));
    if (got.cell_data !== want.cell_data)
      log_failure($sformatf("cell_data expected 0x%04h got 0x%04h",
                            want.cell_data, got.cell_data));
  endtask

  always @(posedge clk) begin
    tcw_out_t want;
    if (rst) begin
      attr = ATTR_RESET;
      blank_screen();
      predicted_results.delete();
      fail_count      = 0;
      results_checked = 0;
      scroll_count    = 0;
    end else begin
      if (cfg_we) attr = cfg_wdata;
      // Retire the result first: it can only belong to an older item.
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          log_failure($sformatf("result beat with nothing expected: %p", out_data));
        end else begin
          want = predicted_results.pop_front();
          compare_result(want, out_data);
          results_checked++;
        end
      end
      if (in_valid && in_ready) predicted_results.push_back(advance_console(in_data));
    end
    pending = predicted_results.size();
  end

endmodule : text_console_char_writer_checker

/* verif/text_console_char_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Drives put, clear and read items into the console writer under changing
// handshake pressure and attribute settings; a side checker predicts and
// compares every result beat, this module only makes stimulus and judges.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;
  import tcw_pkg::*;

  // Action code the block leaves unused
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 400;
  // A scroll sweeps the whole store, so give the tail a full sweep and margin
  localparam int SETTLE_CYCLES = CELLS + 64;
  // Worst case: every item scrolls, plus stalls, reset clearing and hold-off
  localparam int RUN_LIMIT     = 6_000_000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  tcw_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  tcw_out_t          out_data;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int results_checked;
  int scroll_count;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asked;
  int hold_served;
  int beats_sent;
  int beats_with_effect;
  int attr_settings;
  int cycle_count;

  text_console_char_writer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  text_console_char_writer_checker i_console_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .scroll_count    (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run: count cycles and give up well past the slowest pass.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
    $display("text_console_char_writer_tb failed");
    $finish;
  end

  // Result side: stall at the current rate, and on request hold off for a
  // long stretch so the block's queue fills and in_ready drops.
  initial begin
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------
  function automatic tcw_in_t beat_of(logic [ACT_W-1:0] act, logic [CHR_W-1:0] code,
                                      logic [IDX_W-1:0] idx);
    tcw_in_t b;
    b.action     = act;
    b.char_code  = code;
    b.cell_index = idx;
    return b;
  endfunction

  function automatic logic [CHR_W-1:0] any_byte();
    return CHR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHR_W-1:0] printable();
    return CHR_W'($urandom_range(CH_TOP, CH_SPACE));
  endfunction

  // Bytes the block drops: low controls other than the three it handles,
  // and the whole upper half.
  function automatic logic [CHR_W-1:0] dropped_byte();
    logic [CHR_W-1:0] c;
    c = CHR_W'($urandom_range(255, 128));
    if ($urandom_range(1) == 0) begin
      c = CHR_W'($urandom_range(31));
      if (c inside {CH_BS, CH_TAB, CH_NL}) c = 8'h00;
    end
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(2**IDX_W - 1));
  endfunction

  // Reads lean toward the bottom rows, where fresh text piles up after
  // scrolling; a few go past the end of the store.
  function automatic logic [IDX_W-1:0] read_index();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return IDX_W'($urandom_range(CELLS - 1, CELLS - 5 * COLUMNS));
    if (pick < 90) return IDX_W'($urandom_range(CELLS - 1));
    return IDX_W'($urandom_range(2**IDX_W - 1, CELLS));
  endfunction

  function automatic bit has_effect(tcw_in_t b);
    if (b.action == ACT_CLEAR || b.action == ACT_READ) return 1'b1;
    if (b.action != ACT_PUT) return 1'b0;
    return (b.char_code inside {CH_BS, CH_TAB, CH_NL}) ||
           (b.char_code >= CH_SPACE && b.char_code <= CH_TOP);
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver: entered just after a rising edge, returns just after the
  // edge that accepted the beat. Valid stays high until then.
  // ---------------------------------------------------------------------------
  task automatic push_item(tcw_in_t beat);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (has_effect(beat)) beats_with_effect++;
  endtask

  // Drop valid before the next edge so the last beat is not taken twice.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Fence with a read: its result leaves only after every older item,
  // scrolls included, has finished, so the block is idle afterwards.
  task automatic settle();
    push_item(beat_of(ACT_READ, any_byte(), read_index()));
    release_input();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    attr_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed items: reset contents, field extremes, every control code,
  // dropped bytes, the unused action and the right-edge wrap.
  // ---------------------------------------------------------------------------
  task automatic directed_items();
    push_item(beat_of(ACT_READ, 8'h00, '0));                   // blank after reset
    push_item(beat_of(ACT_READ, 8'hFF, IDX_W'(CELLS - 1)));    // last cell
    push_item(beat_of(ACT_READ, 8'h00, '1));                   // past the store
    push_item(beat_of(ACT_PUT, CH_SPACE, '1));                 // lowest printable
    push_item(beat_of(ACT_PUT, CH_TOP, '0));                   // highest printable
    push_item(beat_of(ACT_PUT, 8'h1F, '0));                    // dropped control
    push_item(beat_of(ACT_PUT, 8'h80, '0));                    // negative as signed
    push_item(beat_of(ACT_PUT, 8'hFF, '1));
    push_item(beat_of(ACT_PUT, 8'h00, '0));
    push_item(beat_of(ACT_PUT, CH_BS, '0));
    push_item(beat_of(ACT_PUT, CH_BS, '0));
    push_item(beat_of(ACT_PUT, CH_BS, '0));                    // stays at column 0
    push_item(beat_of(ACT_PUT, CH_TAB, '0));
    push_item(beat_of(ACT_PUT, 8'h41, '0));
    push_item(beat_of(ACT_PUT, CH_TAB, '0));                   // off a tab stop
    push_item(beat_of(ACT_NONE, 8'hFF, '1));                   // unused action
    repeat (8) push_item(beat_of(ACT_PUT, CH_TAB, '0));        // run off the right edge
    push_item(beat_of(ACT_READ, 8'h00, IDX_W'(1)));
    push_item(beat_of(ACT_PUT, CH_NL, '0));
    push_item(beat_of(ACT_CLEAR, 8'h00, '0));
    push_item(beat_of(ACT_READ, 8'h00, IDX_W'(8)));
  endtask

  // ---------------------------------------------------------------------------
  // Random bursts: mostly lines of text and newline runs so the cursor
  // reaches the bottom and the screen scrolls; reads, cursor moves, noise
  // and the odd clear in between.
  // ---------------------------------------------------------------------------
  task automatic random_burst();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 40) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(12, 1);
      repeat (len) push_item(beat_of(ACT_PUT, printable(), any_index()));
      if ($urandom_range(9) < 7) push_item(beat_of(ACT_PUT, CH_NL, any_index()));
    end else if (pick < 55) begin
      repeat ($urandom_range(8, 1)) push_item(beat_of(ACT_PUT, CH_NL, any_index()));
    end else if (pick < 70) begin
      repeat ($urandom_range(4, 1)) push_item(beat_of(ACT_READ, any_byte(), read_index()));
    end else if (pick < 78) begin
      repeat ($urandom_range(6, 1))
        push_item(beat_of(ACT_PUT, ($urandom_range(1) != 0) ? CH_TAB : CH_BS, any_index()));
    end else if (pick < 90) begin
      if ($urandom_range(1) != 0)
        push_item(beat_of(ACT_NONE, any_byte(), any_index()));
      else
        push_item(beat_of(ACT_PUT, dropped_byte(), any_index()));
    end else if (pick < 92) begin
      push_item(beat_of(ACT_CLEAR, any_byte(), any_index()));
    end else begin
      push_item(beat_of(ACT_PUT, any_byte(), any_index()));
    end
  endtask

  task automatic run_phase(int target);
    int goal;
    goal = beats_with_effect + target;
    while (beats_with_effect < goal) random_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    in_data           = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    tx_idle_pct       = 38;
    rx_idle_pct       = 61;
    hold_asked        = 0;
    beats_sent        = 0;
    beats_with_effect = 0;
    attr_settings     = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset attribute first; in_ready stays low through the clearing pass.
    directed_items();
    settle();

    // Sender idles more lightly than the receiver, darkest attribute.
    write_attribute(8'h00);
    run_phase(PHASE_ITEMS);
    settle();

    // Swap the idling rates, brightest attribute.
    tx_idle_pct = 61;
    rx_idle_pct = 38;
    write_attribute(8'hFF);
    run_phase(PHASE_ITEMS);
    settle();

    // Full rate, opening with a long receiver hold-off to back up the block.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_attribute(ATTR_W'($urandom_range(254, 1)));
    hold_asked++;
    run_phase(PHASE_ITEMS);
    release_input();

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d beats (%0d with effect), %0d results checked, %0d scrolls",
             beats_sent, beats_with_effect, results_checked, scroll_count);
    $display("%0d attribute settings, three idling mixes and one %0d-cycle hold-off, %0d fails",
             attr_settings, HOLD_CYCLES, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("text_console_char_writer_tb passed");
    end else begin
      $display("text_console_char_writer_tb failed");
    end
    $finish;
  end

endmodule : text_console_char_writer_tb
